>>> sv/hsds_pkg.sv
// ----------------------------------------------------------------------------
// hsds_pkg: shared types and constants of the bucketed hash set
// Operation codes, sequencer states, the reset bucket count and the sum width.
// ----------------------------------------------------------------------------
package hsds_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_TEST   = 2'd2;

	localparam logic [4:0] BUCKET_COUNT_RESET = 5'd16;

	localparam int unsigned SUM_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_MOD,
		ST_SCAN,
		ST_WAIT,
		ST_DONE
	} state_t;

endpackage

>>> sv/hsds_digit_sum.sv
// ----------------------------------------------------------------------------
// hsds_digit_sum: iterative decimal digit sum
// Peels one decimal digit per cycle off the key magnitude and accumulates
// the ASCII codes of the key's decimal text.
// ----------------------------------------------------------------------------
module hsds_digit_sum #(
	parameter int unsigned KEY_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_WIDTH-1:0]          key,
	output logic                          done,
	output logic [hsds_pkg::SUM_W-1:0]    sum
);

	// Division by ten as a multiplication by the rounded-up reciprocal
	// 2^(KEY_WIDTH+4)/10 followed by a shift; exact for every magnitude.
	localparam int unsigned SH = KEY_WIDTH + 4;
	localparam logic [SH:0] POW2 = {1'b1, {SH{1'b0}}};
	localparam logic [SH:0] RECIP_W = (POW2 + (SH+1)'(9)) / (SH+1)'(10);
	localparam logic [KEY_WIDTH:0] RECIP = RECIP_W[KEY_WIDTH:0];

	logic [KEY_WIDTH-1:0]       mag_q;
	logic [hsds_pkg::SUM_W-1:0] sum_q;
	logic                       busy_q;
	logic [KEY_WIDTH-1:0]       quot;
	logic [3:0]                 digit;
	logic [2*KEY_WIDTH:0]       prod;
	logic                       last_digit;

	always_comb begin
		prod  = (2*KEY_WIDTH+1)'(mag_q) * (2*KEY_WIDTH+1)'(RECIP);
		quot  = KEY_WIDTH'(prod >> SH);
		digit = 4'(mag_q - ((quot << 3) + (quot << 1)));
	end

	// The last digit is reached once the magnitude is a single digit.
	assign last_digit = mag_q < KEY_WIDTH'(10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && last_digit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (key[KEY_WIDTH-1]) begin
				mag_q <= KEY_WIDTH'(0) - key;
				sum_q <= hsds_pkg::SUM_W'(45);
			end else begin
				mag_q <= key;
				sum_q <= '0;
			end
		end else if (busy_q) begin
			mag_q <= quot;
			sum_q <= sum_q + hsds_pkg::SUM_W'(48) + hsds_pkg::SUM_W'(digit);
		end
	end

	assign done = busy_q && last_digit;
	assign sum  = sum_q + hsds_pkg::SUM_W'(48) + hsds_pkg::SUM_W'(digit);

endmodule

>>> sv/hsds_ctrl.sv
// ----------------------------------------------------------------------------
// hsds_ctrl: request sequencer
// Reduces the sum modulo the bucket count by repeated subtraction, scans the
// bucket one slot per cycle and applies the update.
// ----------------------------------------------------------------------------
module hsds_ctrl #(
	parameter int unsigned NUM_BUCKETS  = 16,
	parameter int unsigned BUCKET_DEPTH = 8,
	parameter int unsigned KEY_WIDTH    = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [1:0]                 op,
	input  logic [KEY_WIDTH-1:0]       key,
	input  logic [4:0]                 bucket_count,
	output logic                       ds_start,
	input  logic                       ds_done,
	input  logic [hsds_pkg::SUM_W-1:0] ds_sum,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic                       found,
	output logic                       status
);

	localparam int unsigned SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
	localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned DW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int unsigned CW    = $clog2(BUCKET_DEPTH + 1);

	hsds_pkg::state_t state_q, state_d;

	logic [KEY_WIDTH-1:0]       keys_mem [SLOTS];
	logic [SLOTS-1:0]           valid_q;
	logic [KEY_WIDTH-1:0]       key_q;
	logic [1:0]                 op_q;
	logic [hsds_pkg::SUM_W-1:0] rem_q;
	logic [hsds_pkg::SUM_W-1:0] mod_n;
	logic [CW-1:0]              idx_q;
	logic                       hit_q, free_ok_q;
	logic [DW-1:0]              hit_slot_q, free_slot_q;
	logic                       found_q, status_q;
	logic [AW-1:0]              base;
	logic [AW-1:0]              rd_addr;
	logic [KEY_WIDTH-1:0]       rd_key_q;
	logic                       rd_valid_q;
	logic                       rd_pend_q;
	logic [DW-1:0]              rd_slot_q;
	logic                       last_idx;

	always_comb begin
		if (bucket_count == 5'd0) begin
			mod_n = hsds_pkg::SUM_W'(1);
		end else if (32'(bucket_count) > NUM_BUCKETS) begin
			mod_n = hsds_pkg::SUM_W'(NUM_BUCKETS);
		end else begin
			mod_n = hsds_pkg::SUM_W'(bucket_count);
		end
	end

	assign base     = AW'(32'(BW'(rem_q)) * BUCKET_DEPTH);
	assign rd_addr  = base + AW'(idx_q);
	assign last_idx = idx_q == CW'(BUCKET_DEPTH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsds_pkg::ST_IDLE:  if (s_tvalid) state_d = hsds_pkg::ST_DIGIT;
			hsds_pkg::ST_DIGIT: if (ds_done) state_d = hsds_pkg::ST_MOD;
			hsds_pkg::ST_MOD:   if (rem_q < mod_n) state_d = hsds_pkg::ST_SCAN;
			hsds_pkg::ST_SCAN:  if (last_idx) state_d = hsds_pkg::ST_WAIT;
			hsds_pkg::ST_WAIT:  if (!rd_pend_q) state_d = hsds_pkg::ST_DONE;
			hsds_pkg::ST_DONE:  if (m_tready) state_d = hsds_pkg::ST_IDLE;
			default:            state_d = hsds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ds_start = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			hsds_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ds_start = s_tvalid;
			end
			hsds_pkg::ST_DONE: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hsds_pkg::ST_IDLE;
			valid_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= state_q == hsds_pkg::ST_SCAN && !last_idx;
			if (state_q == hsds_pkg::ST_WAIT && !rd_pend_q) begin
				if (op_q == hsds_pkg::OP_INSERT && !hit_q && free_ok_q) begin
					valid_q[base + AW'(free_slot_q)] <= 1'b1;
				end else if (op_q == hsds_pkg::OP_REMOVE && hit_q) begin
					valid_q[base + AW'(hit_slot_q)] <= 1'b0;
				end
			end
		end
	end

	// Key store: one read port during the scan, one write at the end.
	always_ff @(posedge clk) begin
		rd_key_q   <= keys_mem[rd_addr];
		rd_valid_q <= valid_q[rd_addr];
		rd_slot_q  <= DW'(idx_q);
		if (state_q == hsds_pkg::ST_WAIT && !rd_pend_q && op_q == hsds_pkg::OP_INSERT
				&& !hit_q && free_ok_q) begin
			keys_mem[base + AW'(free_slot_q)] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hsds_pkg::ST_IDLE: begin
				key_q <= key;
				op_q  <= op;
			end
			hsds_pkg::ST_DIGIT: begin
				rem_q     <= ds_sum;
				idx_q     <= '0;
				hit_q     <= 1'b0;
				free_ok_q <= 1'b0;
			end
			hsds_pkg::ST_MOD: if (rem_q >= mod_n) rem_q <= rem_q - mod_n;
			default: ;
		endcase
		if (state_q == hsds_pkg::ST_SCAN && !last_idx) idx_q <= idx_q + CW'(1);
		if (rd_pend_q) begin
			if (rd_valid_q) begin
				if (!hit_q && rd_key_q == key_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= rd_slot_q;
				end
			end else if (!free_ok_q) begin
				free_ok_q   <= 1'b1;
				free_slot_q <= rd_slot_q;
			end
		end
		if (state_q == hsds_pkg::ST_WAIT && !rd_pend_q) begin
			found_q  <= hit_q;
			status_q <= op_q == hsds_pkg::OP_INSERT && !hit_q && !free_ok_q;
		end
	end

	assign found  = found_q;
	assign status = status_q;

endmodule

>>> sv/hash_set_digit_sum_buckets_top.sv
// ----------------------------------------------------------------------------
// hash_set_digit_sum_buckets_top: bucketed hash set of signed keys
// Insert, remove and membership test, one request at a time.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: tdata carries key (bits 0..KEY_WIDTH-1) and the
// operation code travels in tuser (0 insert, 1 remove, 2 test; 3 acts as a
// test). One result per request leaves on the m_ channel with found in
// tdata bit 0 and status (insert dropped, bucket full) in bit 1.
// The block works on one request at a time and drops s_tready until the
// result has been transferred. After acceptance a request passes through the
// digit sum, one decimal digit of the key at a time, the modulo, one
// subtraction of the bucket count from the digit sum at a time plus a final
// compare, the scan of the bucket one slot per cycle through the key store's
// single read port and the update; then the result is offered. Smaller bucket
// counts lengthen the modulo. A stalled receiver simply holds the result
// and the input stays not ready. Reset empties the set at once (valid
// flags clear) and restores a bucket count of 16; the count may be
// rewritten through cfg_we/cfg_data while idle.
// ----------------------------------------------------------------------------
module hash_set_digit_sum_buckets_top #(
	parameter int unsigned NUM_BUCKETS  = 16,
	parameter int unsigned BUCKET_DEPTH = 8,
	parameter int unsigned KEY_WIDTH    = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [KEY_WIDTH-1:0] s_tdata,  // key
	input  logic [1:0]           s_tuser,  // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata   // found, status, zero fill
);

	logic [4:0]                 bucket_count_q;
	logic                       ds_start, ds_done;
	logic [hsds_pkg::SUM_W-1:0] ds_sum;
	logic                       found, status;

	// The bucket count register is the only configuration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= hsds_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_data;
		end
	end

	hsds_digit_sum #(.KEY_WIDTH(KEY_WIDTH)) u_sum (
		.clk(clk), .arst_n(arst_n), .start(ds_start), .key(s_tdata),
		.done(ds_done), .sum(ds_sum)
	);

	hsds_ctrl #(
		.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH), .KEY_WIDTH(KEY_WIDTH)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.op(s_tuser), .key(s_tdata), .bucket_count(bucket_count_q),
		.ds_start(ds_start), .ds_done(ds_done), .ds_sum(ds_sum),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .found(found), .status(status)
	);

	assign m_tdata = {6'b0, status, found};

endmodule

>>> sv/hsds_checker.sv
// ----------------------------------------------------------------------------
// hsds_checker: port-level checks of the hash set
// Watches handshakes and result encoding on the top level ports.
// ----------------------------------------------------------------------------
module hsds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// One request at a time: never ready while a result is waiting.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accepting while result pending");

	// An accepted request takes the block out of ready at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");

	// A full bucket can only drop an insert of an absent key.
	a_status_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1])) else $error("found with drop");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

endmodule

bind hash_set_digit_sum_buckets_top hsds_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
